/* hw/rtl/integer_to_ascii_formatter_assert.svh */
// Assertion macros used by the formatter checker
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define I2A_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("formatter port check failed");

// Next-cycle implication, sampled on the block clock, off during reset
`define I2A_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("formatter port check failed");

`endif

/* hw/rtl/i2a_pkg.sv */
// Shared types, codes and character table of the integer to ASCII formatter
package i2a_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_DEC  = 2'd0;
   localparam opcode_type OP_FIX  = 2'd1;
   localparam opcode_type OP_HEX  = 2'd2;
   localparam opcode_type OP_NONE = 2'd3;

   localparam int VALUE_W  = 32;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = DIGITS * 4;
   localparam int HEX_MAX  = 8;

   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_POINT = 7'h2E;

   localparam logic [6:0] HEX_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   function automatic logic [6:0] nibble_char(input logic [3:0] nib);
      return HEX_CHARS[nib];
   endfunction

endpackage

/* hw/rtl/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter: top level with shift-add-3 converter and emitter
// A transaction is taken when start is high and busy is low; busy then stays high
// until the last character has been shown. Characters come out one per cycle on
// rsp_char_code with rsp_strobe high for that single cycle, and rsp_last marks the
// final one; the receiver cannot stall, so it must take every strobed character.
// Decimal and fixed-two items load, run the shared shift-add-3 binary-to-BCD unit,
// drop leading zero digits and pick the first kept one, then show a minus sign
// for a negative value, the digits and, for fixed-two, a point before the last
// two digits.
// Hex items skip the converter: they load, drop unused nibbles, pick the first
// digit, then show the digits.
// Opcode 3 is taken without raising busy and produces nothing.
module integer_to_ascii_formatter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  i2a_pkg::opcode_type  req_opcode,
   input  logic signed [31:0]   req_value,
   input  logic [3:0]           req_hex_digits,
   output logic                 rsp_strobe,
   output logic [6:0]           rsp_char_code,
   output logic                 rsp_last
);
   import i2a_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_SKIP  = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_DIGIT = 6'b010000,
      ST_POINT = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;
   logic [4:0]            iter_ff, iter_in;
   logic [3:0]            dcnt_ff, dcnt_in;
   logic [3:0]            limit_ff, limit_in;
   logic [VALUE_W-1:0]    raw;
   logic [3:0]            top_nib;
   logic                  skip;

   assign raw     = VALUE_W'(req_value);
   assign top_nib = bcd_ff[BCD_W-1 -: 4];
   assign skip    = (dcnt_ff > limit_ff) && ((op_ff == OP_HEX) || (top_nib == 4'd0));

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                        : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      iter_in  = iter_ff;
      dcnt_in  = dcnt_ff;
      limit_in = limit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_opcode;
               neg_in  = raw[VALUE_W-1];
               bin_in  = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
               bcd_in  = '0;
               iter_in = '0;
               dcnt_in = 4'(DIGITS);
               limit_in = (req_opcode == OP_FIX) ? 4'd3 : 4'd1;
               priority if (req_opcode == OP_HEX) begin
                  bcd_in  = {raw, 8'h00};
                  dcnt_in = 4'(HEX_MAX);
                  priority if (req_hex_digits == 4'd0) limit_in = 4'd1;
                  else if (req_hex_digits > 4'(HEX_MAX)) limit_in = 4'(HEX_MAX);
                  else limit_in = req_hex_digits;
                  state_in = ST_SKIP;
               end else if (req_opcode == OP_DEC || req_opcode == OP_FIX) begin
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(VALUE_W - 1)) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (skip) begin
               // drop a leading zero digit, or an unused hex nibble
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'h0};
               dcnt_in = dcnt_ff - 4'd1;
            end else begin
               state_in = (neg_ff && op_ff != OP_HEX) ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            bcd_in  = {bcd_ff[BCD_W-5:0], 4'h0};
            dcnt_in = dcnt_ff - 4'd1;
            priority if (dcnt_ff == 4'd1) state_in = ST_IDLE;
            else if (op_ff == OP_FIX && dcnt_ff == 4'd3) state_in = ST_POINT;
            else state_in = ST_DIGIT;
         end
         ST_POINT: begin
            state_in = ST_DIGIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      neg_ff   <= neg_in;
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      iter_ff  <= iter_in;
      dcnt_ff  <= dcnt_in;
      limit_ff <= limit_in;
   end

   always_comb begin
      unique case (state_ff)
         ST_SIGN:  rsp_char_code = CHAR_MINUS;
         ST_POINT: rsp_char_code = CHAR_POINT;
         default:  rsp_char_code = nibble_char(top_nib);
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_SIGN) || (state_ff == ST_DIGIT) ||
                       (state_ff == ST_POINT);
   assign rsp_last   = (state_ff == ST_DIGIT) && (dcnt_ff == 4'd1);

endmodule

/* hw/rtl/i2a_checker.sv */
// Port-level checker for the integer to ASCII formatter, with its bind
`include "integer_to_ascii_formatter_assert.svh"

module i2a_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input i2a_pkg::opcode_type  req_opcode,
   input logic                 rsp_strobe,
   input logic [6:0]           rsp_char_code,
   input logic                 rsp_last
);
   import i2a_pkg::*;

   // a character only appears inside a transaction
   `I2A_ASSERT_SAME(a_strobe_busy, rsp_strobe, busy)

   // a real format opcode starts a run
   `I2A_ASSERT_NEXT(a_start_busy, start && !busy && req_opcode != OP_NONE, busy)

   // the run ends right after its last character
   `I2A_ASSERT_NEXT(a_last_ends, rsp_strobe && rsp_last, !busy)

   // busy drops only after a last character
   `I2A_ASSERT_SAME(a_end_last, $fell(busy) && !$past(reset), $past(rsp_strobe && rsp_last))

   // only digits, upper-case hex letters, minus and point are emitted
   `I2A_ASSERT_SAME(a_char_set, rsp_strobe, (rsp_char_code >= 7'h30 && rsp_char_code <= 7'h39) || (rsp_char_code >= 7'h41 && rsp_char_code <= 7'h46) || rsp_char_code == CHAR_MINUS || rsp_char_code == CHAR_POINT)

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_opcode    (req_opcode),
   .rsp_strobe    (rsp_strobe),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last)
);
